[hdl/aft_pkg.sv]
// Shared constants, types and score arithmetic for the focus table.
`timescale 1ns / 1ps
`default_nettype none
package aft_pkg;
   localparam int TABLE_SIZE_DEF = 64;
   localparam int ID_BITS_DEF    = 16;
   localparam int SCORE_W        = 19;
   localparam int SCORE_LIMIT    = 256000;

   localparam logic [1:0] CMD_FOCUS = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_DECAY = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [1:0] CSR_FOCUS_BOOST = 2'd0;
   localparam logic [1:0] CSR_SCORE_MAX   = 2'd1;
   localparam logic [1:0] CSR_DECAY_RATE  = 2'd2;
   localparam logic [1:0] CSR_EVICT_THR   = 2'd3;

   localparam logic [17:0] FOCUS_BOOST_RST = 18'd25600;
   localparam logic [17:0] SCORE_MAX_RST   = 18'd256000;
   localparam logic [15:0] DECAY_RATE_RST  = 16'd655;
   localparam logic [17:0] EVICT_THR_RST   = 18'd256;

   typedef struct packed {
      logic [17:0] focus_boost;
      logic [17:0] score_max;
      logic [15:0] decay_rate;
      logic [17:0] evict_threshold;
   } cfg_type;

   // saturate to [-limit, min(score_max, limit)]
   function automatic logic signed [18:0] clamp_score(input logic signed [20:0] v,
                                                      input logic [17:0] smax);
      logic [17:0]        hi;
      logic signed [20:0] his;
      hi  = (smax > 18'(SCORE_LIMIT)) ? 18'(SCORE_LIMIT) : smax;
      his = signed'(21'(hi));
      if (v > his) begin
         clamp_score = 19'(his);
      end else if (v < -21'sd256000) begin
         clamp_score = -19'sd256000;
      end else begin
         clamp_score = 19'(v);
      end
   endfunction
endpackage
`default_nettype wire

[hdl/aft_if.sv]
// Request, response and register-write channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface aft_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [15:0]        atom_id;
   logic signed [18:0] atom_score;
   logic signed [18:0] amount;
   modport source (output valid, cmd, atom_id, atom_score, amount, input ready);
   modport sink   (input valid, cmd, atom_id, atom_score, amount, output ready);
endinterface

interface aft_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        out_id;
   logic signed [18:0] new_score;
   logic               in_focus;
   logic               removed;
   logic               last;
   modport source (output valid, out_id, new_score, in_focus, removed, last, input ready);
   modport sink   (input valid, out_id, new_score, in_focus, removed, last, output ready);
endinterface

interface aft_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [17:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/attention_focus_table_core.sv]
// Focus table top level: register file and sequencer.
// Focus/allocate: each entry is read and compared, then a final step writes and responds;
// an empty table takes only that final step. Decay: each entry is read and decayed, with one
// response each; a stalled response holds the walk. The entry memory's read is registered.
// Reset (synchronous, active high) empties the table and restores register defaults.
// The response register lets the next request enter while a response waits.
`timescale 1ns / 1ps
`default_nettype none
module attention_focus_table_core #(
   parameter int TABLE_SIZE = aft_pkg::TABLE_SIZE_DEF,
   parameter int ID_BITS    = aft_pkg::ID_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   aft_req_if.sink   req_ch,
   aft_rsp_if.source rsp_ch,
   aft_csr_if.sink   csr_ch
);
   aft_pkg::cfg_type cfg_ff, cfg_in;

   // register writes always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            aft_pkg::CSR_FOCUS_BOOST: cfg_in.focus_boost     = csr_ch.data;
            aft_pkg::CSR_SCORE_MAX:   cfg_in.score_max       = csr_ch.data;
            aft_pkg::CSR_DECAY_RATE:  cfg_in.decay_rate      = csr_ch.data[15:0];
            aft_pkg::CSR_EVICT_THR:   cfg_in.evict_threshold = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focus_boost     <= aft_pkg::FOCUS_BOOST_RST;
         cfg_ff.score_max       <= aft_pkg::SCORE_MAX_RST;
         cfg_ff.decay_rate      <= aft_pkg::DECAY_RATE_RST;
         cfg_ff.evict_threshold <= aft_pkg::EVICT_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer owns the entry memory and the response register
   aft_ctrl #(
      .TABLE_SIZE (TABLE_SIZE),
      .ID_BITS    (ID_BITS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );
endmodule
`default_nettype wire

[hdl/aft_decay.sv]
// Decay of one score by (1 - rate), rounding half away from zero, plus eviction test.
`timescale 1ns / 1ps
`default_nettype none
module aft_decay (
   input  wire logic signed [18:0] score,
   input  wire logic [15:0]        rate,
   input  wire logic [17:0]        thr,
   output logic signed [18:0]      new_score,
   output logic                    evict
);
   logic        neg;
   logic [17:0] mag;
   logic [16:0] fac;
   logic [34:0] prod;
   logic [18:0] q;

   always_comb begin
      neg  = score[18];
      mag  = neg ? 18'(-score) : 18'(score);
      fac  = 17'd65536 - 17'(rate);
      prod = 35'(mag) * 35'(fac) + 35'd32768;
      q    = prod[34:16];
      new_score = neg ? -signed'(q) : signed'(q);
      evict = 20'(new_score) < signed'(20'(thr));
   end
endmodule
`default_nettype wire

[hdl/aft_ctrl.sv]
// Entry memory and the sequencer that scans, updates and compacts it.
`timescale 1ns / 1ps
`default_nettype none
module aft_ctrl #(
   parameter int TABLE_SIZE = aft_pkg::TABLE_SIZE_DEF,
   parameter int ID_BITS    = aft_pkg::ID_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire aft_pkg::cfg_type cfg,
   aft_req_if.sink           req,
   aft_rsp_if.source         rsp
);
   localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CW = $clog2(TABLE_SIZE + 1);
   localparam int EW = ID_BITS + aft_pkg::SCORE_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RD   = 4'b0010,
      S_PROC = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic signed [18:0] ns_ff, ns_in;
   logic [CW-1:0]      idx_ff, idx_in, wr_ff, wr_in, count_ff, count_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      pos_ff, pos_in, minpos_ff, minpos_in;
   logic signed [18:0] min_ff, min_in;

   logic               ov_ff, ov_in;
   logic [15:0]        oid_ff, oid_in;
   logic signed [18:0] osc_ff, osc_in;
   logic               ofoc_ff, ofoc_in, orem_ff, orem_in, olast_ff, olast_in;

   logic [EW-1:0] mem [TABLE_SIZE];
   logic [EW-1:0] rdata_ff;
   logic          we;
   logic [AW-1:0] waddr;
   logic [EW-1:0] wdata;

   logic [ID_BITS-1:0] e_id;
   logic signed [18:0] e_sc, d_sc;
   logic               d_ev, out_free, is_last;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   assign e_id = rdata_ff[EW-1 -: ID_BITS];
   assign e_sc = signed'(rdata_ff[aft_pkg::SCORE_W-1:0]);

   aft_decay u_decay (
      .score     (e_sc),
      .rate      (cfg.decay_rate),
      .thr       (cfg.evict_threshold),
      .new_score (d_sc),
      .evict     (d_ev)
   );

   assign out_free  = !ov_ff || rsp.ready;
   assign is_last   = CW'(idx_ff + CW'(1)) == count_ff;
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;  cmd_in = cmd_ff;  id_in = id_ff;  ns_in = ns_ff;
      idx_in = idx_ff;  wr_in = wr_ff;  count_in = count_ff;
      found_in = found_ff;  pos_in = pos_ff;  min_in = min_ff;  minpos_in = minpos_ff;
      ov_in = ov_ff && !rsp.ready;
      oid_in = oid_ff;  osc_in = osc_ff;  ofoc_in = ofoc_ff;
      orem_in = orem_ff;  olast_in = olast_ff;
      we = 1'b0;  waddr = '0;  wdata = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in   = req.cmd;
               id_in    = ID_BITS'(req.atom_id);
               idx_in   = '0;
               wr_in    = '0;
               found_in = 1'b0;
               if (req.cmd == aft_pkg::CMD_FOCUS) begin
                  ns_in = aft_pkg::clamp_score(21'(req.atom_score)
                                               + signed'(21'(cfg.focus_boost)),
                                               cfg.score_max);
               end else begin
                  ns_in = aft_pkg::clamp_score(21'(req.atom_score) + 21'(req.amount),
                                               cfg.score_max);
               end
               if (req.cmd == aft_pkg::CMD_FOCUS || req.cmd == aft_pkg::CMD_ALLOC) begin
                  state_in = (count_ff == '0) ? S_FIN : S_RD;
               end else if (req.cmd == aft_pkg::CMD_DECAY && count_ff != '0) begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: state_in = S_PROC;
         S_PROC: begin
            if (cmd_ff == aft_pkg::CMD_DECAY) begin
               if (out_free) begin
                  ov_in = 1'b1;  oid_in = 16'(e_id);  osc_in = d_sc;
                  ofoc_in = !d_ev;  orem_in = d_ev;  olast_in = is_last;
                  if (!d_ev) begin
                     we = 1'b1;  waddr = wr_ff[AW-1:0];  wdata = {e_id, d_sc};
                  end
                  wr_in = wr_ff + CW'(!d_ev);
                  if (is_last) begin
                     count_in = wr_ff + CW'(!d_ev);
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + CW'(1);
                     state_in = S_RD;
                  end
               end
            end else begin
               if (e_id == id_ff && !found_ff) begin
                  found_in = 1'b1;  pos_in = idx_ff[AW-1:0];
               end
               // first minimal score wins
               if (idx_ff == '0 || e_sc < min_ff) begin
                  min_in = e_sc;  minpos_in = idx_ff[AW-1:0];
               end
               if (is_last) begin
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               ov_in = 1'b1;  oid_in = 16'(id_ff);  osc_in = ns_ff;
               orem_in = 1'b0;  olast_in = 1'b1;
               wdata = {id_ff, ns_ff};
               ofoc_in = found_ff;
               if (found_ff) begin
                  we = 1'b1;  waddr = pos_ff;
               end else if (cmd_ff == aft_pkg::CMD_FOCUS) begin
                  if (count_ff < CW'(TABLE_SIZE)) begin
                     we = 1'b1;  waddr = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);  ofoc_in = 1'b1;
                  end else if (ns_ff > min_ff) begin
                     we = 1'b1;  waddr = minpos_ff;  ofoc_in = 1'b1;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff    <= ov_in;
      end
      cmd_ff <= cmd_in;  id_ff <= id_in;  ns_ff <= ns_in;
      idx_ff <= idx_in;  wr_ff <= wr_in;  found_ff <= found_in;
      pos_ff <= pos_in;  min_ff <= min_in;  minpos_ff <= minpos_in;
      oid_ff <= oid_in;  osc_ff <= osc_in;  ofoc_ff <= ofoc_in;
      orem_ff <= orem_in;  olast_ff <= olast_in;
   end

   assign rsp.valid     = ov_ff;
   assign rsp.out_id    = oid_ff;
   assign rsp.new_score = osc_ff;
   assign rsp.in_focus  = ofoc_ff;
   assign rsp.removed   = orem_ff;
   assign rsp.last      = olast_ff;
endmodule
`default_nettype wire

[verif/tb_attention_focus_table_core.sv]
// Testbench for the focus table core: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_attention_focus_table_core;

   localparam int TABLE_DEPTH = 64;
   localparam int IDLE_LIMIT  = 20000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [15:0]        atom_id;
      logic signed [18:0] atom_score;
      logic signed [18:0] amount;
   } request_type;

   typedef struct packed {
      logic [15:0]        out_id;
      logic signed [18:0] new_score;
      logic               in_focus;
      logic               removed;
      logic               last;
   } score_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aft_req_if req_ch ();
   aft_rsp_if rsp_ch ();
   aft_csr_if csr_ch ();

   attention_focus_table_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [17:0]        boost_q, smax_q, thr_q;
   logic [15:0]        rate_q;
   logic [15:0]        tbl_id    [TABLE_DEPTH];
   logic signed [18:0] tbl_score [TABLE_DEPTH];
   int                 tbl_count;

   request_type      pending_requests [$];
   score_update_type expected_updates [$];
   int               error_count   = 0;
   int               idle_cycles   = 0;
   bit               rsp_hold_long = 1'b0;
   bit               sender_pause  = 1'b0;
   bit               req_taken     = 1'b0;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [18:0] sat_score(input longint v);
      longint hi;
      hi = (smax_q > 18'd256000) ? 256000 : longint'(smax_q);
      if (v > hi) return 19'(hi);
      if (v < -256000) return -19'sd256000;
      return 19'(v);
   endfunction

   function automatic logic signed [18:0] decayed(input logic signed [18:0] s);
      longint m;
      m = (s < 0) ? -longint'(s) : longint'(s);
      m = (m * (65536 - longint'(rate_q)) + 32768) >>> 16;
      return (s < 0) ? 19'(-m) : 19'(m);
   endfunction

   // apply one accepted request to the table model and queue its updates
   task automatic predict_updates(input request_type rq);
      score_update_type   u;
      logic signed [18:0] ns, mv;
      int                 pos, mi, w, n;
      bit                 dropped;
      u   = '0;
      pos = -1;
      if (rq.cmd == aft_pkg::CMD_FOCUS || rq.cmd == aft_pkg::CMD_ALLOC) begin
         for (int i = tbl_count - 1; i >= 0; i--) begin
            if (tbl_id[i] == rq.atom_id) pos = i;
         end
      end
      case (rq.cmd)
         aft_pkg::CMD_FOCUS: begin
            ns = sat_score(longint'(rq.atom_score) + longint'(boost_q));
            u.in_focus = 1'b1;
            if (pos >= 0) begin
               tbl_score[pos] = ns;
            end else if (tbl_count < TABLE_DEPTH) begin
               tbl_id[tbl_count]    = rq.atom_id;
               tbl_score[tbl_count] = ns;
               tbl_count++;
            end else begin
               // full: replace the first lowest entry if strictly beaten
               mi = 0;
               mv = tbl_score[0];
               for (int i = 1; i < tbl_count; i++) begin
                  if (tbl_score[i] < mv) begin
                     mv = tbl_score[i];
                     mi = i;
                  end
               end
               if (ns > mv) begin
                  tbl_id[mi]    = rq.atom_id;
                  tbl_score[mi] = ns;
               end else begin
                  u.in_focus = 1'b0;
               end
            end
            u.out_id = rq.atom_id; u.new_score = ns; u.last = 1'b1;
            expected_updates.push_back(u);
         end
         aft_pkg::CMD_ALLOC: begin
            ns = sat_score(longint'(rq.atom_score) + longint'(rq.amount));
            if (pos >= 0) tbl_score[pos] = ns;
            u.out_id = rq.atom_id; u.new_score = ns; u.in_focus = (pos >= 0); u.last = 1'b1;
            expected_updates.push_back(u);
         end
         aft_pkg::CMD_DECAY: begin
            n = tbl_count;
            w = 0;
            for (int i = 0; i < n; i++) begin
               ns      = decayed(tbl_score[i]);
               dropped = (longint'(ns) < longint'(thr_q));
               u.out_id    = tbl_id[i];
               u.new_score = ns;
               u.in_focus  = !dropped;
               u.removed   = dropped;
               u.last      = (i == n - 1);
               expected_updates.push_back(u);
               if (!dropped) begin
                  tbl_id[w]    = tbl_id[i];
                  tbl_score[w] = ns;
                  w++;
               end
            end
            tbl_count = w;
         end
         default: ;  // unused code: no effect
      endcase
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // request driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_taken) begin
         // hold the offered request
      end else if (req_gap > 0) begin
         req_gap--;
         req_ch.valid <= 1'b0;
      end else if (!sender_pause && pending_requests.size() > 0) begin
         request_type rq;
         rq = pending_requests.pop_front();
         req_taken = 1'b0;
         req_ch.valid      <= 1'b1;
         req_ch.cmd        <= rq.cmd;
         req_ch.atom_id    <= rq.atom_id;
         req_ch.atom_score <= rq.atom_score;
         req_ch.amount     <= rq.amount;
         req_gap = gap_len();
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // accepted requests feed the predictor
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         request_type rq;
         rq.cmd = req_ch.cmd; rq.atom_id = req_ch.atom_id;
         rq.atom_score = req_ch.atom_score; rq.amount = req_ch.amount;
         req_taken = 1'b1;
         predict_updates(rq);
      end
   end

   // response ready: random stalls, plus a long hold when requested
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (reset || rsp_hold_long) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_gap = gap_len();
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         score_update_type e;
         if (expected_updates.size() == 0) begin
            report_mismatch("unexpected response id", rsp_ch.out_id, -1);
         end else begin
            e = expected_updates.pop_front();
            if (rsp_ch.out_id !== e.out_id) report_mismatch("out_id", rsp_ch.out_id, e.out_id);
            if (rsp_ch.new_score !== e.new_score)
               report_mismatch("new_score", rsp_ch.new_score, e.new_score);
            if (rsp_ch.in_focus !== e.in_focus)
               report_mismatch("in_focus", rsp_ch.in_focus, e.in_focus);
            if (rsp_ch.removed !== e.removed)
               report_mismatch("removed", rsp_ch.removed, e.removed);
            if (rsp_ch.last !== e.last) report_mismatch("last", rsp_ch.last, e.last);
         end
      end
   end

   // watchdog: cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || rsp_hold_long)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic request_type mk_req(input logic [1:0] c, input logic [15:0] id,
                                          input int sc, input int am);
      request_type r;
      r.cmd = c; r.atom_id = id; r.atom_score = 19'(sc); r.amount = 19'(am);
      return r;
   endfunction

   function automatic int rnd_score();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 256000;
      if (r == 1) return -256000;
      if (r < 5) return int'($urandom_range(0, 512000)) - 256000;
      return int'($urandom_range(0, 20000)) - 10000;
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_ch.valid || expected_updates.size() > 0)
         @(posedge clock);
      // then allow time for a full table walk
      repeat (2 * TABLE_DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1; csr_ch.index <= idx; csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         aft_pkg::CSR_FOCUS_BOOST: boost_q = val;
         aft_pkg::CSR_SCORE_MAX:   smax_q  = val;
         aft_pkg::CSR_DECAY_RATE:  rate_q  = val[15:0];
         default:                  thr_q   = val;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // random mix of focus/allocate/decay and unused codes, mostly on a small id pool
   task automatic random_phase(input int count, input int id_span);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            pending_requests.push_back(mk_req(aft_pkg::CMD_FOCUS,
               16'($urandom_range(0, id_span)), rnd_score(), 0));
         else if (r < 75)
            pending_requests.push_back(mk_req(aft_pkg::CMD_ALLOC,
               16'($urandom_range(0, id_span)), rnd_score(), rnd_score()));
         else if (r < 92)
            pending_requests.push_back(mk_req(aft_pkg::CMD_DECAY, 16'($urandom),
               rnd_score(), 0));
         else if (r < 96)
            pending_requests.push_back(mk_req(aft_pkg::CMD_NONE, 16'($urandom),
               rnd_score(), 0));
         else
            pending_requests.push_back(mk_req(aft_pkg::CMD_FOCUS, 16'($urandom),
               rnd_score(), 0));
      end
   endtask

   initial begin
      req_ch.valid = 1'b0; req_ch.cmd = aft_pkg::CMD_NONE; req_ch.atom_id = '0;
      req_ch.atom_score = '0; req_ch.amount = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.index = aft_pkg::CSR_FOCUS_BOOST; csr_ch.data = '0;
      boost_q = aft_pkg::FOCUS_BOOST_RST; smax_q = aft_pkg::SCORE_MAX_RST;
      rate_q = aft_pkg::DECAY_RATE_RST; thr_q = aft_pkg::EVICT_THR_RST;
      tbl_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: defaults, clamp extremes, duplicate, unused code, empty decay
      pending_requests.push_back(mk_req(aft_pkg::CMD_DECAY, 16'h0, 0, 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_FOCUS, 16'hFFFF, 256000, 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_FOCUS, 16'h0000, -256000, 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_FOCUS, 16'hFFFF, -100, 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_ALLOC, 16'h0000, 256000, 256000));
      pending_requests.push_back(mk_req(aft_pkg::CMD_ALLOC, 16'h1234, -256000, -256000));
      pending_requests.push_back(mk_req(aft_pkg::CMD_ALLOC, 16'hFFFF, -300, 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_NONE, 16'h0000, 5, 5));
      pending_requests.push_back(mk_req(aft_pkg::CMD_FOCUS, 16'h5555, -25600, 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_DECAY, 16'hAAAA, 0, 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_DECAY, 16'h0, 0, 0));
      wait_drained();

      // extreme settings: near-full decay, highest score max, zero boost, zero threshold
      write_reg(aft_pkg::CSR_FOCUS_BOOST, 18'd0);
      write_reg(aft_pkg::CSR_SCORE_MAX, 18'h3FFFF);
      write_reg(aft_pkg::CSR_DECAY_RATE, 18'd65535);
      write_reg(aft_pkg::CSR_EVICT_THR, 18'd0);
      for (int k = 0; k < 8; k++)
         pending_requests.push_back(mk_req(aft_pkg::CMD_FOCUS, 16'(k), rnd_score(), 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_DECAY, 16'h0, 0, 0));
      pending_requests.push_back(mk_req(aft_pkg::CMD_DECAY, 16'h0, 0, 0));
      wait_drained();

      // fill past capacity with the receiver held off so the block backs up
      write_reg(aft_pkg::CSR_FOCUS_BOOST, 18'd256000);
      write_reg(aft_pkg::CSR_SCORE_MAX, 18'd1000);
      write_reg(aft_pkg::CSR_DECAY_RATE, 18'd0);
      write_reg(aft_pkg::CSR_EVICT_THR, 18'h3FFFF);
      rsp_hold_long = 1'b1;
      for (int k = 0; k < 70; k++)
         pending_requests.push_back(mk_req(aft_pkg::CMD_FOCUS, 16'(k * 7 + 1),
            rnd_score(), 0));
      repeat (600) @(posedge clock);
      rsp_hold_long = 1'b0;
      wait_drained();
      pending_requests.push_back(mk_req(aft_pkg::CMD_DECAY, 16'h0, 0, 0));
      wait_drained();

      // defaults-like settings with random traffic, sender pause in the middle
      write_reg(aft_pkg::CSR_FOCUS_BOOST, aft_pkg::FOCUS_BOOST_RST);
      write_reg(aft_pkg::CSR_SCORE_MAX, aft_pkg::SCORE_MAX_RST);
      write_reg(aft_pkg::CSR_DECAY_RATE, 18'd8000);
      write_reg(aft_pkg::CSR_EVICT_THR, 18'd256);
      random_phase(30, 90);
      wait(pending_requests.size() < 15);
      sender_pause = 1'b1;
      wait(expected_updates.size() == 0 && !req_ch.valid);
      sender_pause = 1'b0;
      random_phase(30, 90);
      wait_drained();

      write_reg(aft_pkg::CSR_DECAY_RATE, 18'd30000);
      write_reg(aft_pkg::CSR_EVICT_THR, 18'd120000);
      write_reg(aft_pkg::CSR_SCORE_MAX, 18'd200000);
      random_phase(28, 70);
      wait_drained();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
